[rtl/core/cbst_pkg.sv]
`timescale 1ns / 1ps

package cbst_pkg;

   localparam int unsigned KEY_W        = 32;
   localparam int unsigned CAPACITY_DEF = 64;
   localparam int unsigned FIFO_DEPTH   = 2;

   typedef struct packed {
      logic signed [KEY_W-1:0] key_value;
      logic                    last_item;
   } req_item_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key_value_out;
      logic                    last_result;
      logic                    overflowed;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_EMIT_START,
      ST_POP,
      ST_RANGE,
      ST_OUT,
      ST_PUSH_HI
   } back_state_type;

endpackage

[rtl/core/cbst_fifo.sv]
`timescale 1ns / 1ps

module cbst_fifo #(
   parameter int unsigned WIDTH = $bits(cbst_pkg::req_item_type),
   parameter int unsigned DEPTH = cbst_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [NW-1:0]    fill_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (fill_ff == NW'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + NW'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - NW'(1);
         end
      end
   end

endmodule

[rtl/core/cbst_back.sv]
`timescale 1ns / 1ps

module cbst_back #(
   parameter int unsigned CAPACITY = cbst_pkg::CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cbst_pkg::req_item_type in_item,
   input  logic                   in_empty,
   output logic                   in_pop,
   output cbst_pkg::rsp_item_type out_item,
   input  logic                   out_full,
   output logic                   out_push
);

   localparam int unsigned AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW     = $clog2(CAPACITY + 1);
   localparam int unsigned QDEPTH = 2 ** AW;

   cbst_pkg::back_state_type state_ff, state_in;

   logic signed [cbst_pkg::KEY_W-1:0] key_ff;
   logic                              last_ff;
   logic                              ovf_ff;
   logic [CW-1:0]                     count_ff;
   logic [CW-1:0]                     pos_ff;
   logic [CW-1:0]                     emitted_ff;
   logic [CW-1:0]                     lo_ff;
   logic [CW-1:0]                     hi_ff;
   logic [CW-1:0]                     root_ff;
   logic [AW-1:0]                     head_ff;
   logic [AW-1:0]                     tail_ff;

   logic signed [cbst_pkg::KEY_W-1:0] store_mem [CAPACITY];
   logic signed [cbst_pkg::KEY_W-1:0] srd_ff;
   logic [2*CW-1:0]                   queue_mem [QDEPTH];
   logic [2*CW-1:0]                   qrd_ff;

   logic                              store_we;
   logic [AW-1:0]                     store_wa;
   logic signed [cbst_pkg::KEY_W-1:0] store_wd;
   logic                              store_re;
   logic [AW-1:0]                     store_ra;
   logic                              q_we;
   logic [AW-1:0]                     q_wa;
   logic [2*CW-1:0]                   q_wd;
   logic                              q_re;

   logic          store_full;
   logic          key_gt;
   logic [CW-1:0] cnt_m1;
   logic [CW-1:0] pos_m1;
   logic [CW-1:0] pos_m2;
   logic [CW-1:0] root_p1;
   logic          set_done;

   logic [CW-1:0] r_lo;
   logic [CW-1:0] r_hi;
   logic [CW-1:0] r_size;
   logic [CW-1:0] r_fill;
   logic [CW:0]   r_quarter;
   logic [CW-1:0] r_slack;
   logic [CW-1:0] r_shift;
   logic [CW-1:0] r_root;

   assign store_full = (count_ff == CW'(CAPACITY));
   assign key_gt     = (srd_ff > key_ff);
   assign cnt_m1     = count_ff - CW'(1);
   assign pos_m1     = pos_ff - CW'(1);
   assign pos_m2     = pos_ff - CW'(2);
   assign root_p1    = root_ff + CW'(1);
   assign set_done   = (emitted_ff == count_ff);

   // root of the complete tree over the popped range
   always_comb begin
      r_lo   = qrd_ff[2*CW-1:CW];
      r_hi   = qrd_ff[CW-1:0];
      r_size = r_hi - r_lo;
      r_fill = r_size;
      for (int i = 1; i < CW; i++) begin
         r_fill = r_fill | (r_fill >> i);
      end
      r_quarter = ({1'b0, r_fill} + (CW+1)'(1)) >> 2;
      r_slack   = r_fill - r_size;
      if ({1'b0, r_slack} > r_quarter) begin
         r_shift = r_slack - r_quarter[CW-1:0];
      end else begin
         r_shift = '0;
      end
      r_root = r_lo + (r_fill >> 1) - r_shift;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbst_pkg::ST_IDLE: begin
            if (!in_empty) begin
               if (store_full) begin
                  state_in = in_item.last_item ? cbst_pkg::ST_EMIT_START : cbst_pkg::ST_IDLE;
               end else if (count_ff == '0) begin
                  state_in = cbst_pkg::ST_INS_PUT;
               end else begin
                  state_in = cbst_pkg::ST_INS_CMP;
               end
            end
         end
         cbst_pkg::ST_INS_CMP: begin
            if (key_gt && pos_m1 != '0) begin
               state_in = cbst_pkg::ST_INS_CMP;
            end else begin
               state_in = cbst_pkg::ST_INS_PUT;
            end
         end
         cbst_pkg::ST_INS_PUT: begin
            state_in = last_ff ? cbst_pkg::ST_EMIT_START : cbst_pkg::ST_IDLE;
         end
         cbst_pkg::ST_EMIT_START: state_in = cbst_pkg::ST_POP;
         cbst_pkg::ST_POP: begin
            state_in = set_done ? cbst_pkg::ST_IDLE : cbst_pkg::ST_RANGE;
         end
         cbst_pkg::ST_RANGE: state_in = cbst_pkg::ST_OUT;
         cbst_pkg::ST_OUT: begin
            state_in = out_full ? cbst_pkg::ST_OUT : cbst_pkg::ST_PUSH_HI;
         end
         cbst_pkg::ST_PUSH_HI: state_in = cbst_pkg::ST_POP;
         default: state_in = cbst_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      in_pop   = 1'b0;
      out_push = 1'b0;
      store_we = 1'b0;
      store_wa = pos_ff[AW-1:0];
      store_wd = key_ff;
      store_re = 1'b0;
      store_ra = cnt_m1[AW-1:0];
      q_we     = 1'b0;
      q_wa     = tail_ff;
      q_wd     = {lo_ff, root_ff};
      q_re     = 1'b0;
      unique case (state_ff)
         cbst_pkg::ST_IDLE: begin
            if (!in_empty) begin
               in_pop   = 1'b1;
               store_re = !store_full && (count_ff != '0);
            end
         end
         cbst_pkg::ST_INS_CMP: begin
            if (key_gt) begin
               // shift the larger key up one slot
               store_we = 1'b1;
               store_wd = srd_ff;
               store_re = (pos_m1 != '0);
               store_ra = pos_m2[AW-1:0];
            end
         end
         cbst_pkg::ST_INS_PUT: store_we = 1'b1;
         cbst_pkg::ST_EMIT_START: begin
            q_we = 1'b1;
            q_wa = '0;
            q_wd = {CW'(0), count_ff};
         end
         cbst_pkg::ST_POP: q_re = !set_done;
         cbst_pkg::ST_RANGE: begin
            store_re = 1'b1;
            store_ra = r_root[AW-1:0];
         end
         cbst_pkg::ST_OUT: begin
            if (!out_full) begin
               out_push = 1'b1;
               q_we     = (root_ff > lo_ff);
            end
         end
         cbst_pkg::ST_PUSH_HI: begin
            q_we = (hi_ff > root_p1);
            q_wd = {root_p1, hi_ff};
         end
         default: begin
         end
      endcase
   end

   assign out_item.key_value_out = srd_ff;
   assign out_item.last_result   = ((emitted_ff + CW'(1)) == count_ff);
   assign out_item.overflowed    = ovf_ff;

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wa] <= store_wd;
      end
      if (store_re) begin
         srd_ff <= store_mem[store_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_wa] <= q_wd;
      end
      if (q_re) begin
         qrd_ff <= queue_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == cbst_pkg::ST_IDLE && !in_empty) begin
         key_ff  <= in_item.key_value;
         last_ff <= in_item.last_item;
      end
      if (state_ff == cbst_pkg::ST_RANGE) begin
         lo_ff   <= r_lo;
         hi_ff   <= r_hi;
         root_ff <= r_root;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= cbst_pkg::ST_IDLE;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         pos_ff     <= '0;
         emitted_ff <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            cbst_pkg::ST_IDLE: begin
               if (!in_empty) begin
                  pos_ff <= count_ff;
                  if (store_full) begin
                     // drop the key, keep the flag for the whole set
                     ovf_ff <= 1'b1;
                  end
               end
            end
            cbst_pkg::ST_INS_CMP: begin
               if (key_gt) begin
                  pos_ff <= pos_m1;
               end
            end
            cbst_pkg::ST_INS_PUT: count_ff <= count_ff + CW'(1);
            cbst_pkg::ST_EMIT_START: begin
               head_ff    <= '0;
               tail_ff    <= AW'(1);
               emitted_ff <= '0;
            end
            cbst_pkg::ST_POP: begin
               if (set_done) begin
                  count_ff <= '0;
                  ovf_ff   <= 1'b0;
               end else begin
                  head_ff <= head_ff + AW'(1);
               end
            end
            cbst_pkg::ST_OUT: begin
               if (!out_full) begin
                  emitted_ff <= emitted_ff + CW'(1);
                  if (q_we) begin
                     tail_ff <= tail_ff + AW'(1);
                  end
               end
            end
            cbst_pkg::ST_PUSH_HI: begin
               if (q_we) begin
                  tail_ff <= tail_ff + AW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

[rtl/core/complete_bst_level_order_top.sv]
`timescale 1ns / 1ps
// channel     | ports                                        | moves
// ------------+----------------------------------------------+---------------------------
// request in  | push, full, req_key_value, req_last_item     | one key, last closes set
// response out| pop, empty, rsp_key_value_out,               | keys in level order
//             | rsp_last_result, rsp_overflowed              |
//
// Each request is placed in the sorted key store of the sort engine by shifting up the
// held keys greater than it (at most CAPACITY - 1); when the store is full the key is
// dropped. A closing request then emits every held key through range queue read, key
// store read, result push with the low range push and high range push, stalling on a
// full response queue. Two-entry queues on both sides let requests wait while the
// engine works; reset is synchronous and empties both queues and the store.

module complete_bst_level_order_top #(
   parameter int unsigned CAPACITY = cbst_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic signed [cbst_pkg::KEY_W-1:0] req_key_value,
   input  logic                              req_last_item,
   input  logic                              pop,
   output logic                              empty,
   output logic signed [cbst_pkg::KEY_W-1:0] rsp_key_value_out,
   output logic                              rsp_last_result,
   output logic                              rsp_overflowed
);

   localparam int unsigned REQ_W = $bits(cbst_pkg::req_item_type);
   localparam int unsigned RSP_W = $bits(cbst_pkg::rsp_item_type);

   cbst_pkg::req_item_type req_wr;
   cbst_pkg::req_item_type req_rd;
   cbst_pkg::rsp_item_type rsp_wr;
   cbst_pkg::rsp_item_type rsp_rd;
   logic [REQ_W-1:0]       req_rd_bits;
   logic [RSP_W-1:0]       rsp_rd_bits;
   logic                   in_empty;
   logic                   in_pop;
   logic                   out_full;
   logic                   out_push;

   assign req_wr.key_value = req_key_value;
   assign req_wr.last_item = req_last_item;
   assign req_rd           = cbst_pkg::req_item_type'(req_rd_bits);
   assign rsp_rd           = cbst_pkg::rsp_item_type'(rsp_rd_bits);

   assign rsp_key_value_out = rsp_rd.key_value_out;
   assign rsp_last_result   = rsp_rd.last_result;
   assign rsp_overflowed    = rsp_rd.overflowed;

   cbst_fifo #(
      .WIDTH (REQ_W),
      .DEPTH (cbst_pkg::FIFO_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (req_wr),
      .full      (full),
      .pop       (in_pop),
      .pop_data  (req_rd_bits),
      .empty     (in_empty)
   );

   cbst_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_item  (req_rd),
      .in_empty (in_empty),
      .in_pop   (in_pop),
      .out_item (rsp_wr),
      .out_full (out_full),
      .out_push (out_push)
   );

   cbst_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (cbst_pkg::FIFO_DEPTH)
   ) u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (rsp_wr),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_rd_bits),
      .empty     (empty)
   );

   a_no_rsp_overrun: assert property (@(posedge clock) disable iff (reset)
      !(out_push && out_full))
      else $error("sort engine pushed into a full response queue");

   a_no_req_underrun: assert property (@(posedge clock) disable iff (reset)
      !(in_pop && in_empty))
      else $error("sort engine took a request from an empty queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not cleared by reset");

endmodule

[tb/sv/complete_bst_level_order_top_test.sv]
`timescale 1ns / 1ps

module complete_bst_level_order_top_test;

   typedef logic signed [cbst_pkg::KEY_W-1:0] key_type;

   localparam int unsigned STORE_DEPTH = cbst_pkg::CAPACITY_DEF;
   localparam int unsigned IDLE_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned PRINT_LIMIT = 30;
   localparam key_type KEY_MIN = {1'b1, {(cbst_pkg::KEY_W-1){1'b0}}};
   localparam key_type KEY_MAX = {1'b0, {(cbst_pkg::KEY_W-1){1'b1}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   key_type req_key_value = '0;
   logic req_last_item = 1'b0;
   logic pop = 1'b0;
   logic empty;
   key_type rsp_key_value_out;
   logic rsp_last_result;
   logic rsp_overflowed;

   complete_bst_level_order_top dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_key_value     (req_key_value),
      .req_last_item     (req_last_item),
      .pop               (pop),
      .empty             (empty),
      .rsp_key_value_out (rsp_key_value_out),
      .rsp_last_result   (rsp_last_result),
      .rsp_overflowed    (rsp_overflowed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted block state
   key_type                sorted_store [STORE_DEPTH];
   int unsigned            held_count = 0;
   logic                   keys_dropped = 1'b0;
   cbst_pkg::rsp_item_type due_results [$];

   int unsigned mismatch_count = 0;
   int unsigned keys_sent = 0;
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned rx_cycle = 0;
   int unsigned stall_left = 0;

   task automatic report_mismatch(input string what, input logic [cbst_pkg::KEY_W-1:0] want,
                                  input logic [cbst_pkg::KEY_W-1:0] got);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch: %s want %h got %h", what, want, got);
      mismatch_count++;
   endtask

   function automatic int unsigned tree_root(input int unsigned lo, input int unsigned hi);
      int unsigned n;
      int unsigned rest;
      int unsigned fill;
      int unsigned quarter;
      int unsigned shift;
      n = hi - lo;
      rest = n;
      fill = 0;
      while (rest > 0) begin
         fill = fill * 2 + 1;
         rest = rest >> 1;
      end
      quarter = (fill + 1) / 4;
      shift = (fill - n > quarter) ? (fill - n - quarter) : 0;
      return lo + fill / 2 - shift;
   endfunction

   // breadth first walk over subranges of the sorted store
   task automatic queue_level_order();
      int unsigned            range_lo [$];
      int unsigned            range_hi [$];
      int unsigned            lo;
      int unsigned            hi;
      int unsigned            root;
      int unsigned            emitted;
      cbst_pkg::rsp_item_type item;
      emitted = 0;
      if (held_count > 0) begin
         range_lo = {range_lo, 0};
         range_hi = {range_hi, held_count};
      end
      while (range_lo.size() > 0) begin
         lo = range_lo.pop_front();
         hi = range_hi.pop_front();
         root = tree_root(lo, hi);
         item.key_value_out = sorted_store[root];
         item.last_result = (emitted + 1 == held_count);
         item.overflowed = keys_dropped;
         due_results = {due_results, item};
         emitted++;
         if (root > lo) begin
            range_lo = {range_lo, lo};
            range_hi = {range_hi, root};
         end
         if (hi > root + 1) begin
            range_lo = {range_lo, root + 1};
            range_hi = {range_hi, hi};
         end
      end
   endtask

   task automatic absorb_key(input key_type key, input logic last);
      int unsigned pos;
      if (held_count >= STORE_DEPTH) begin
         keys_dropped = 1'b1;
      end else begin
         // equal keys stay behind the ones already held
         pos = held_count;
         while (pos > 0 && sorted_store[pos-1] > key) begin
            sorted_store[pos] = sorted_store[pos-1];
            pos--;
         end
         sorted_store[pos] = key;
         held_count++;
      end
      if (last) begin
         queue_level_order();
         held_count = 0;
         keys_dropped = 1'b0;
      end
   endtask

   // call at a falling edge; returns at a falling edge
   task automatic send_key(input key_type key, input logic last);
      int unsigned gap;
      req_key_value <= key;
      req_last_item <= last;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      absorb_key(key, last);
      keys_sent++;
      @(negedge clock);
      if (burst_left > 1) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12);
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic send_set(input key_type keys[$]);
      foreach (keys[i])
         send_key(keys[i], i == keys.size() - 1);
   endtask

   function automatic key_type random_key();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         1, 2: return $signed($urandom_range(0, 8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      key_type keys [$];
      keys = '{KEY_MAX};
      send_set(keys);
      keys = '{KEY_MIN};
      send_set(keys);
      // sign ordering across zero and the extremes
      keys = '{key_type'(0), key_type'(-1), key_type'(1), KEY_MAX, KEY_MIN};
      send_set(keys);
      keys = '{key_type'(5), key_type'(5), key_type'(-5), key_type'(5), key_type'(5)};
      send_set(keys);
      // descending order forces the longest shifts
      keys = '{key_type'(6), key_type'(5), key_type'(4), key_type'(3), key_type'(2),
               key_type'(1), key_type'(0)};
      send_set(keys);
      keys = '{key_type'(-100), key_type'(100)};
      send_set(keys);
   endtask

   task automatic test_full_store();
      key_type keys [$];
      // fill the store, then drop a plain key and the closing key
      repeat (STORE_DEPTH + 2) keys = {keys, random_key()};
      send_set(keys);
   endtask

   task automatic test_random_sets();
      key_type keys [$];
      int unsigned set_size;
      int unsigned start;
      start = keys_sent;
      while (keys_sent - start < 35) begin
         set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 30)
                                                : $urandom_range(1, 10);
         keys.delete();
         repeat (set_size) keys = {keys, random_key()};
         send_set(keys);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      cbst_pkg::rsp_item_type want;
      if (!reset && pop && !empty) begin
         if (due_results.size() == 0) begin
            report_mismatch("unexpected key", '0, rsp_key_value_out);
         end else begin
            want = due_results.pop_front();
            if (rsp_key_value_out !== want.key_value_out)
               report_mismatch("key_value_out", want.key_value_out, rsp_key_value_out);
            if (rsp_last_result !== want.last_result)
               report_mismatch("last_result", want.last_result, rsp_last_result);
            if (rsp_overflowed !== want.overflowed)
               report_mismatch("overflowed", want.overflowed, rsp_overflowed);
         end
      end
   end

   // receiver stall pattern: free-running stretches, then random and long stalls
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         pop <= 1'b0;
      end else if (rx_cycle % 1500 < 300) begin
         pop <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 24);
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_full_store();
      test_random_sets();
      push <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_results.size() != 0)
         report_mismatch("results left over", due_results.size(), '0);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[complete_bst_level_order_top.f]
rtl/core/cbst_pkg.sv
rtl/core/cbst_fifo.sv
rtl/core/cbst_back.sv
rtl/core/complete_bst_level_order_top.sv
tb/sv/complete_bst_level_order_top_test.sv
